>>> rtl/sffp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffp_pkg
// Shared types and constants for the flowgram file stream parser.
// ----------------------------------------------------------------------------
package sffp_pkg;

  typedef enum logic [3:0] {
    ST_COMMON, ST_FLOWCH, ST_KEY, ST_HSKIP, ST_RHDR, ST_NAME, ST_HPAD,
    ST_FLOW, ST_INDEX, ST_BASE, ST_QUAL, ST_DPAD, ST_IDLE
  } sect_t;

  typedef enum logic [3:0] {
    K_FILE_HDR = 4'd0, K_FLOW_CHAR = 4'd1, K_KEY_CHAR = 4'd2, K_READ_HDR = 4'd3,
    K_NAME = 4'd4, K_FLOW = 4'd5, K_INDEX = 4'd6, K_BASE = 4'd7,
    K_QUAL = 4'd8, K_ERROR = 4'd9
  } kind_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FORMAT = 2'd1;
  localparam logic [1:0] ERR_BASE   = 2'd2;

  localparam logic [7:0] QUAL_OFFSET = 8'd33;
  localparam logic [16:0] RHDR_FIXED = 17'd16;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // One classified element, handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic [39:0] value;
    logic [31:0] position;
    logic [31:0] read_number;
    logic [15:0] clip0;
    logic [15:0] clip1;
    logic [15:0] clip2;
    logic [15:0] clip3;
    logic [1:0]  err;
    logic        last;
  } elem_t;

endpackage

>>> rtl/sff_record_stream_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_record_stream_parser_unit
// Flowgram file stream parser: byte in, classified elements out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | data_byte, start_of_file
//  output  | out_valid/out_stall| out_kind .. last (one element per transfer)
//
//  One byte per cycle while the queue is not full; the parser state is registered.
//  A result passes through the queue write and then the output register
//  before it is valid.
//  A four-entry queue sits between parser and output; input stalls only
//  when it is full.
//  Synchronous active-high reset returns to the start of the common header.
module sff_record_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [39:0] value,
  output logic [31:0] position,
  output logic [31:0] read_number,
  output logic [15:0] qual_clip_left,
  output logic signed [17:0] qual_clip_span,
  output logic [15:0] adapter_clip_left,
  output logic signed [17:0] adapter_clip_span,
  output logic [1:0]  error_code,
  output logic        last
);
  import sffp_pkg::*;

  logic  push, pop, q_full, q_nonempty;
  elem_t push_elem, head;

  sffp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .start_of_file,
    .q_full, .push, .push_elem
  );

  sffp_queue u_queue (
    .clk, .rst, .push, .push_elem, .full(q_full), .pop,
    .nonempty(q_nonempty), .head
  );

  sffp_back u_back (
    .clk, .rst, .nonempty(q_nonempty), .head, .pop, .out_valid, .out_stall,
    .out_kind, .value, .position, .read_number, .qual_clip_left, .qual_clip_span,
    .adapter_clip_left, .adapter_clip_span, .error_code, .last
  );

endmodule

>>> rtl/sffp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffp_front
// Byte parser: walks file and read sections, emits at most one element per byte.
// ----------------------------------------------------------------------------
module sffp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          start_of_file,
  input  logic          q_full,
  output logic          push,
  output sffp_pkg::elem_t push_elem
);
  import sffp_pkg::*;

  sect_t       st, st_next;
  logic [31:0] cnt, cnt_next;
  logic [23:0] shift, shift_next;
  logic [15:0] offset, offset_next;
  logic [15:0] hdr_len, hdr_len_next;
  logic [15:0] key_len, key_len_next;
  logic [15:0] fpr, fpr_next;
  logic [31:0] rif, rif_next;
  logic [31:0] rd, rd_next;
  logic [31:0] total, total_next;
  logic [15:0] rh_len, rh_len_next;
  logic [15:0] nm_len, nm_len_next;
  logic [31:0] bc, bc_next;
  logic [15:0] clip [4];
  logic [15:0] clip_next [4];
  logic [39:0] isum, isum_next;
  logic [1:0]  err, err_next;

  logic        accept, emit;
  elem_t       e;
  sect_t       s_eff;
  logic [31:0] c_eff, c_inc, rd_eff;
  logic [31:0] sh_new;
  logic [16:0] need;
  logic [16:0] hpad;
  logic [2:0]  dpad;
  sect_t       fin_st, dpad_st, index_st, flow_st, hpad_st, name_st;
  logic        dpad_fin, index_fin, flow_fin, hpad_fin, name_fin;
  sect_t       reads_st, hskip_st, key_st, flowch_st;
  logic        enter;
  logic        do_fin;
  logic [7:0]  b;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = data_byte;

  // Section lengths derived from the current read header and the common header
  assign need = {1'b0, nm_len} + RHDR_FIXED;
  assign hpad = ({1'b0, rh_len} > need) ? ({1'b0, rh_len} - need) : 17'd0;
  assign dpad = 3'd0 - (fpr[2:0] + fpr[2:0] + bc[2:0] + bc[2:0] + bc[2:0]);

  // Resolve section skip chains
  always_comb begin
    fin_st    = (rd + 32'd1 < rif) ? ST_RHDR : ST_IDLE;
    dpad_fin  = (dpad == 3'd0);
    dpad_st   = dpad_fin ? fin_st : ST_DPAD;
    index_fin = (bc == 32'd0) && dpad_fin;
    index_st  = (bc != 32'd0) ? ST_INDEX : dpad_st;
    flow_fin  = (fpr == 16'd0) && index_fin;
    flow_st   = (fpr != 16'd0) ? ST_FLOW : index_st;
    hpad_fin  = (hpad == 17'd0) && flow_fin;
    hpad_st   = (hpad != 17'd0) ? ST_HPAD : flow_st;
    name_fin  = (nm_len == 16'd0) && hpad_fin;
    name_st   = (nm_len != 16'd0) ? ST_NAME : hpad_st;
    reads_st  = (rd_eff < rif) ? ST_RHDR : ST_IDLE;
    hskip_st  = (offset_next < hdr_len) ? ST_HSKIP : reads_st;
    key_st    = (key_len != 16'd0) ? ST_KEY : hskip_st;
    flowch_st = (fpr != 16'd0) ? ST_FLOWCH : key_st;
  end

  // Next state of the parser
  always_comb begin
    s_eff  = start_of_file ? ST_COMMON : st;
    c_eff  = start_of_file ? 32'd0 : cnt;
    rd_eff = start_of_file ? 32'd0 : rd;
    c_inc  = c_eff + 32'd1;
    sh_new = {(start_of_file ? 24'd0 : shift), b};
    st_next = st; cnt_next = cnt; shift_next = shift;
    offset_next = offset; hdr_len_next = hdr_len; key_len_next = key_len;
    fpr_next = fpr; rif_next = rif; rd_next = rd; total_next = total;
    rh_len_next = rh_len; nm_len_next = nm_len; bc_next = bc;
    clip_next = clip; isum_next = isum; err_next = err;
    enter = 1'b0; do_fin = 1'b0; emit = 1'b0;
    e = '0;
    e.read_number = total;
    if (accept) begin
      if (start_of_file) begin
        st_next = ST_COMMON; cnt_next = '0; shift_next = '0;
        offset_next = '0; rd_next = '0; err_next = ERR_NONE;
      end
      if (start_of_file || err == ERR_NONE) begin
        offset_next = (start_of_file) ? 16'd1 :
                      (offset != 16'hFFFF) ? offset + 16'd1 : offset;
        cnt_next = c_inc;
        unique case (s_eff)
          ST_COMMON: begin
            shift_next = sh_new[23:0];
            if (c_eff == 32'd23) rif_next = sh_new;
            else if (c_eff == 32'd25) hdr_len_next = sh_new[15:0];
            else if (c_eff == 32'd27) key_len_next = sh_new[15:0];
            else if (c_eff == 32'd29) fpr_next = sh_new[15:0];
            else if (c_eff == 32'd30) begin
              emit = 1'b1; enter = 1'b1;
              if (b != 8'd1) begin
                err_next = ERR_FORMAT; st_next = ST_IDLE;
                e.kind = K_ERROR; e.value = {32'd0, b}; e.err = ERR_FORMAT;
              end else begin
                st_next = flowch_st;
                e.kind = K_FILE_HDR; e.value = {24'd0, fpr}; e.read_number = rif;
              end
            end
          end
          ST_FLOWCH, ST_KEY: begin
            emit = 1'b1;
            e.kind = (s_eff == ST_FLOWCH) ? K_FLOW_CHAR : K_KEY_CHAR;
            e.value = {32'd0, b}; e.position = c_eff;
            if (s_eff == ST_FLOWCH) begin
              if (c_inc >= {16'd0, fpr}) begin enter = 1'b1; st_next = key_st; end
            end else if (c_inc >= {16'd0, key_len}) begin
              enter = 1'b1; st_next = hskip_st;
            end
          end
          ST_HSKIP: begin
            if (offset_next >= hdr_len) begin enter = 1'b1; st_next = reads_st; end
          end
          ST_RHDR: begin
            shift_next = sh_new[23:0];
            if (c_eff == 32'd1) rh_len_next = sh_new[15:0];
            else if (c_eff == 32'd3) nm_len_next = sh_new[15:0];
            else if (c_eff == 32'd7) bc_next = sh_new;
            else if (c_eff >= 32'd9 && c_eff <= 32'd15 && c_eff[0])
              clip_next[c_eff[2:1]] = sh_new[15:0];
            if (c_eff == 32'd15) begin
              emit = 1'b1; enter = 1'b1; isum_next = '0;
              st_next = name_st; do_fin = name_fin;
              e.kind = K_READ_HDR; e.value = {8'd0, bc};
              e.clip0 = clip[0]; e.clip1 = clip[1]; e.clip2 = clip[2];
              e.clip3 = sh_new[15:0];
              e.last = (nm_len == 16'd0) && (fpr == 16'd0) && (bc == 32'd0);
            end
          end
          ST_NAME: begin
            emit = 1'b1;
            e.kind = K_NAME; e.value = {32'd0, b}; e.position = c_eff;
            if (c_inc >= {16'd0, nm_len}) begin
              enter = 1'b1; st_next = hpad_st; do_fin = hpad_fin;
              e.last = (fpr == 16'd0) && (bc == 32'd0);
            end
          end
          ST_HPAD: begin
            if (c_inc >= {15'd0, hpad}) begin
              enter = 1'b1; st_next = flow_st; do_fin = flow_fin;
            end
          end
          ST_FLOW: begin
            shift_next = sh_new[23:0];
            if (c_inc[0] == 1'b0) begin
              emit = 1'b1;
              e.kind = K_FLOW; e.value = {24'd0, sh_new[15:0]};
              e.position = {1'b0, c_eff[31:1]};
              if ({1'b0, c_inc[31:1]} >= {16'd0, fpr}) begin
                enter = 1'b1; st_next = index_st; do_fin = index_fin;
                e.last = (bc == 32'd0);
              end
            end
          end
          ST_INDEX: begin
            emit = 1'b1;
            isum_next = isum + {32'd0, b};
            e.kind = K_INDEX; e.value = isum_next; e.position = c_eff;
            if (c_inc >= bc) begin enter = 1'b1; st_next = ST_BASE; end
          end
          ST_BASE: begin
            emit = 1'b1; e.position = c_eff; e.value = {32'd0, b};
            if (b != "A" && b != "C" && b != "G" && b != "T" && b != "N") begin
              err_next = ERR_BASE; enter = 1'b1; st_next = ST_IDLE;
              e.kind = K_ERROR; e.err = ERR_BASE;
            end else begin
              e.kind = K_BASE;
              if (c_inc >= bc) begin enter = 1'b1; st_next = ST_QUAL; end
            end
          end
          ST_QUAL: begin
            emit = 1'b1;
            e.kind = K_QUAL; e.value = {32'd0, b}; e.position = c_eff;
            if (c_inc >= bc) begin
              enter = 1'b1; st_next = dpad_st; do_fin = dpad_fin; e.last = 1'b1;
            end
          end
          ST_DPAD: begin
            if (c_inc >= {29'd0, dpad}) begin
              enter = 1'b1; st_next = fin_st; do_fin = 1'b1;
            end
          end
          ST_IDLE: begin
            cnt_next = cnt;
          end
          default: begin
            cnt_next = cnt;
          end
        endcase
        if (enter) begin
          cnt_next = '0; shift_next = '0;
        end
        if (do_fin) begin
          rd_next = rd + 32'd1; total_next = total + 32'd1;
        end
      end
    end
  end

  assign push      = accept && emit;
  assign push_elem = e;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_COMMON; cnt <= '0; shift <= '0; offset <= '0;
      hdr_len <= '0; key_len <= '0; fpr <= '0; rif <= '0; rd <= '0;
      total <= '0; rh_len <= '0; nm_len <= '0; bc <= '0;
      clip <= '{default: '0}; isum <= '0; err <= ERR_NONE;
    end else begin
      st <= st_next; cnt <= cnt_next; shift <= shift_next; offset <= offset_next;
      hdr_len <= hdr_len_next; key_len <= key_len_next; fpr <= fpr_next;
      rif <= rif_next; rd <= rd_next; total <= total_next; rh_len <= rh_len_next;
      nm_len <= nm_len_next; bc <= bc_next; clip <= clip_next; isum <= isum_next;
      err <= err_next;
    end
  end

  // Checks
  a_push_acc: assert property (@(posedge clk) disable iff (rst) push |-> accept)
    else $error("push without accepted byte");
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE && !start_of_file) |-> !push)
    else $error("element emitted after latched error");
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE) |-> (st == ST_IDLE))
    else $error("error latched outside idle section");

endmodule

>>> rtl/sffp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffp_queue
// Short element queue between the parser front and the output back.
// ----------------------------------------------------------------------------
module sffp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sffp_pkg::elem_t push_elem,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output sffp_pkg::elem_t head
);
  import sffp_pkg::*;

  elem_t          slots [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count, count_next;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rptr];
  assign count_next = count + (QAW+1)'(push) - (QAW+1)'(pop);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count_next;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_elem;
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_unf: assert property (@(posedge clk) disable iff (rst) !nonempty |-> !pop)
    else $error("queue underflow");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/sffp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffp_back
// Output stage: formats queued elements into result fields and holds them.
// ----------------------------------------------------------------------------
module sffp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            nonempty,
  input  sffp_pkg::elem_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      out_kind,
  output logic [39:0]     value,
  output logic [31:0]     position,
  output logic [31:0]     read_number,
  output logic [15:0]     qual_clip_left,
  output logic signed [17:0] qual_clip_span,
  output logic [15:0]     adapter_clip_left,
  output logic signed [17:0] adapter_clip_span,
  output logic [1:0]      error_code,
  output logic            last
);
  import sffp_pkg::*;

  logic        is_hdr;
  logic [39:0] val_fmt;
  logic [17:0] qw, aw;

  assign pop    = nonempty && (!out_valid || !out_stall);
  assign is_hdr = (head.kind == K_READ_HDR);

  // Format value and clip widths
  always_comb begin
    val_fmt = head.value;
    if (head.kind == K_QUAL) val_fmt = {32'd0, head.value[7:0] + QUAL_OFFSET};
    qw = {2'b00, head.clip1} + 18'd1 - {2'b00, head.clip0};
    aw = {2'b00, head.clip3} + 18'd1 - {2'b00, head.clip2};
  end

  // Hold valid until transfer
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind          <= head.kind;
      value             <= val_fmt;
      position          <= head.position;
      read_number       <= head.read_number;
      qual_clip_left    <= is_hdr ? head.clip0 : 16'd0;
      qual_clip_span    <= is_hdr ? qw : 18'sd0;
      adapter_clip_left <= is_hdr ? head.clip2 : 16'd0;
      adapter_clip_span <= is_hdr ? aw : 18'sd0;
      error_code        <= head.err;
      last              <= head.last;
    end
  end

  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (nonempty && (!out_valid || !out_stall)))
    else $error("pop with no room");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> (out_kind == K_ERROR))
    else $error("error code on non-error element");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (nonempty && !out_valid) |=> out_valid)
    else $error("output stage did not fill");

endmodule
